// ===== rtl/qdd_pkg.sv =====
// ----------------------------------------------------------------------------
// qdd_pkg
// Shared types, constants and lookup functions for the quadrature decoder
// with button debounce.
// ----------------------------------------------------------------------------
package qdd_pkg;

   localparam int REQ_DATA_W = 40;   // 35 payload bits padded to whole bytes
   localparam int RSP_DATA_W = 8;    // 4 payload bits padded to whole bytes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_SENSITIVITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_DIR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUAD_TMO    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE    = 2'd3;

   localparam logic [7:0] QUAD_TMO_RESET = 8'd80;
   localparam logic [7:0] DEBOUNCE_RESET = 8'd20;

   localparam logic [7:0] SENS_TH1 = 8'd13;
   localparam logic [7:0] SENS_TH2 = 8'd9;
   localparam logic [7:0] SENS_TH3 = 8'd5;

   typedef enum logic [1:0] {
      STEP_NONE = 2'd0,
      STEP_POS  = 2'd1,
      STEP_NEG  = 2'd2
   } step_type;

   // delta for transition {prev[1:0], cur[1:0]}; double-bit changes count 0
   function automatic logic signed [1:0] trans_delta(input logic [3:0] idx);
      logic signed [1:0] d;
      case (idx)
         4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
         default: d = 2'sd0;
      endcase
      return d;
   endfunction

   function automatic logic [2:0] threshold_of(input logic [7:0] s);
      logic [2:0] th;
      if (s >= SENS_TH1) th = 3'd1;
      else if (s >= SENS_TH2) th = 3'd2;
      else if (s >= SENS_TH3) th = 3'd3;
      else th = 3'd4;
      return th;
   endfunction

endpackage

// ===== rtl/quadrature_decoder_with_debounce.sv =====
// ----------------------------------------------------------------------------
// quadrature_decoder_with_debounce
// Turns timestamped encoder phase and button samples into step and
// debounced button events, one result per sample.
// ----------------------------------------------------------------------------
//  channel   dir  fields (low bit up)
//  req_*     in   time_ms[31:0] phase_a[32] phase_b[33] button_raw[34]
//  rsp_*     out  step[1:0] press_event[2] button_level[3]
//  csr_*     in   0 sensitivity, 1 direction invert, 2 quad_timeout_ms,
//                 3 debounce_ms
//
//  One sample accepted per clock; its result is registered and shows in
//  the next cycle. Decoder and debounce state update in the accepting
//  cycle, so the next sample may follow at once. A sample is accepted
//  while the result register is empty or being drained. Synchronous reset
//  loads the register defaults and clears all state but the result fields.
// ----------------------------------------------------------------------------
module quadrature_decoder_with_debounce (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // time_ms[31:0], phase_a[32], phase_b[33], button_raw[34], zero pad
   input  logic [qdd_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // step[1:0], press_event[2], button_level[3], zero pad
   output logic [qdd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                          csr_we,
   input  logic [qdd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [qdd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import qdd_pkg::*;

   // configuration
   logic [7:0]        sens_ff;
   logic              invert_ff;
   logic [7:0]        qtmo_ff;
   logic [7:0]        dbnc_ff;

   // decoder / debounce state
   logic [1:0]        prev_ph_ff, prev_ph_in;
   logic signed [3:0] accum_ff, accum_in;
   logic [31:0]       edge_t_ff, edge_t_in;
   logic              raw_btn_ff, raw_btn_in;
   logic              stable_ff, stable_in;
   logic [31:0]       chg_t_ff, chg_t_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   step_type          step_ff, step_in;
   logic              press_ff, press_in;
   logic              level_ff;

   logic              accept;
   logic [31:0]       now;
   logic [1:0]        cur;
   logic              btn;
   logic signed [1:0] delta;
   logic signed [3:0] th_s;
   logic signed [3:0] base;
   logic signed [3:0] sum;
   logic [31:0]       q_elapsed;
   logic [31:0]       b_elapsed;
   logic              q_timeout;
   logic              dir_pos, dir_neg;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign now = req_tdata[31:0];
   assign cur = {req_tdata[32], req_tdata[33]};
   assign btn = req_tdata[34];

   assign delta     = trans_delta({prev_ph_ff, cur});
   assign th_s      = $signed({1'b0, threshold_of(sens_ff)});
   assign q_elapsed = now - edge_t_ff;
   assign q_timeout = q_elapsed > {24'd0, qtmo_ff};
   assign base      = q_timeout ? 4'sd0 : accum_ff;
   assign sum       = base + 4'(delta);

   always_comb begin
      prev_ph_in = prev_ph_ff;
      edge_t_in  = edge_t_ff;
      accum_in   = accum_ff;
      dir_pos    = 1'b0;
      dir_neg    = 1'b0;
      if (cur != prev_ph_ff) begin
         prev_ph_in = cur;
         edge_t_in  = now;
         accum_in   = base;
         if (delta != 2'sd0) begin
            if (sum >= th_s) begin
               accum_in = 4'sd0;
               dir_pos  = 1'b1;
            end else if (sum <= -th_s) begin
               accum_in = 4'sd0;
               dir_neg  = 1'b1;
            end else begin
               accum_in = sum;
            end
         end
      end else if (accum_ff != 4'sd0 && q_timeout) begin
         accum_in = 4'sd0;
      end
   end

   always_comb begin
      if (dir_pos != invert_ff && (dir_pos || dir_neg)) step_in = STEP_POS;
      else if (dir_pos || dir_neg) step_in = STEP_NEG;
      else step_in = STEP_NONE;
   end

   // debounce: a raw change restarts the stable-time window
   assign raw_btn_in = btn;
   assign chg_t_in   = (btn != raw_btn_ff) ? now : chg_t_ff;
   assign b_elapsed  = now - chg_t_in;

   always_comb begin
      stable_in = stable_ff;
      press_in  = 1'b0;
      if (b_elapsed >= {24'd0, dbnc_ff} && stable_ff != raw_btn_in) begin
         stable_in = raw_btn_in;
         press_in  = raw_btn_in;
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff      <= 8'd0;
         invert_ff    <= 1'b0;
         qtmo_ff      <= QUAD_TMO_RESET;
         dbnc_ff      <= DEBOUNCE_RESET;
         prev_ph_ff   <= 2'd0;
         accum_ff     <= 4'sd0;
         edge_t_ff    <= 32'd0;
         raw_btn_ff   <= 1'b0;
         stable_ff    <= 1'b0;
         chg_t_ff     <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_SENSITIVITY: sens_ff   <= csr_wdata;
               CSR_INVERT_DIR:  invert_ff <= csr_wdata[0];
               CSR_QUAD_TMO:    qtmo_ff   <= csr_wdata;
               CSR_DEBOUNCE:    dbnc_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            prev_ph_ff <= prev_ph_in;
            accum_ff   <= accum_in;
            edge_t_ff  <= edge_t_in;
            raw_btn_ff <= raw_btn_in;
            stable_ff  <= stable_in;
            chg_t_ff   <= chg_t_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         step_ff  <= step_in;
         press_ff <= press_in;
         level_ff <= stable_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, level_ff, press_ff, step_ff};

   // ---------------------------------------------------------------------
   ap_accum_range: assert property (@(posedge clock) disable iff (reset)
      (accum_ff >= -4'sd4) && (accum_ff <= 4'sd4))
      else $error("step accumulator out of range");

   ap_press_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2]) |-> rsp_tdata[3])
      else $error("press event without pressed level");

   ap_step_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] != 2'd3))
      else $error("illegal step code");

   ap_accept_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted request produced no result");

   ap_press_edge: assert property (@(posedge clock) disable iff (reset)
      (accept && press_in) |-> !stable_ff)
      else $error("press flagged while already pressed");

endmodule

// ===== dv/quadrature_decoder_with_debounce_tb.sv =====
// ----------------------------------------------------------------------------
// quadrature_decoder_with_debounce_tb
// Streams timestamped encoder/button samples into the decoder under bursty
// request traffic and a stalling receiver, predicts every result with an
// independent decoder/debounce model and checks each response field.
// Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module quadrature_decoder_with_debounce_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qdd_pkg::*;

   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic [31:0] time_ms;
      logic        phase_a;
      logic        phase_b;
      logic        button_raw;
   } sample_type;

   typedef struct packed {
      step_type step;
      logic     press;
      logic     level;
   } report_type;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BUSY} rx_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   quadrature_decoder_with_debounce dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // decoder model: registers and state
   logic [7:0]        cfg_sens     = 8'd0;
   logic              cfg_invert   = 1'b0;
   logic [7:0]        cfg_tmo      = QUAD_TMO_RESET;
   logic [7:0]        cfg_debounce = DEBOUNCE_RESET;
   logic [1:0]        enc_last     = 2'd0;
   logic signed [3:0] enc_count    = 4'sd0;
   logic [31:0]       enc_edge_ms  = 32'd0;
   logic              btn_seen     = 1'b0;
   logic              btn_stable   = 1'b0;
   logic [31:0]       btn_since_ms = 32'd0;

   sample_type sample_queue[$];
   report_type awaited_reports[$];
   int      queued_total = 0;
   int      req_sent     = 0;
   int      req_seen     = 0;
   int      mismatches   = 0;
   int      quiet_cycles = 0;

   // stimulus cursor
   logic [31:0] stim_ms  = 32'd0;
   logic [1:0]  stim_pos = 2'd0;
   logic        stim_btn = 1'b0;
   logic        stim_fwd = 1'b1;

   // 2-bit gray <-> binary; the map is its own inverse
   function automatic logic [1:0] gray_flip(input logic [1:0] v);
      return {v[1], v[1] ^ v[0]};
   endfunction

   // a forward move along the gray sequence counts down
   function automatic logic signed [3:0] quad_delta(input logic [1:0] from_ph,
                                                     input logic [1:0] to_ph);
      logic [1:0] moved;
      moved = gray_flip(to_ph) - gray_flip(from_ph);
      case (moved)
         2'd1: return -4'sd1;
         2'd3: return 4'sd1;
         default: return 4'sd0;
      endcase
   endfunction

   function automatic logic signed [3:0] step_threshold(input logic [7:0] s);
      if (s >= SENS_TH1) return 4'sd1;
      if (s >= SENS_TH2) return 4'sd2;
      if (s >= SENS_TH3) return 4'sd3;
      return 4'sd4;
   endfunction

   task automatic decode_sample(input sample_type s, output report_type r);
      logic [1:0]        now_ph;
      logic signed [3:0] d;
      logic signed [3:0] th;
      logic [31:0]       elapsed;
      int                dir;
      now_ph  = {s.phase_a, s.phase_b};
      elapsed = s.time_ms - enc_edge_ms;
      dir     = 0;
      r.press = 1'b0;
      if (now_ph != enc_last) begin
         d  = quad_delta(enc_last, now_ph);
         th = step_threshold(cfg_sens);
         if (elapsed > {24'd0, cfg_tmo}) enc_count = 4'sd0;
         enc_last    = now_ph;
         enc_edge_ms = s.time_ms;
         if (d != 4'sd0) begin
            enc_count = enc_count + d;
            if (enc_count >= th) begin
               enc_count = 4'sd0;
               dir = 1;
            end else if (enc_count <= -th) begin
               enc_count = 4'sd0;
               dir = -1;
            end
         end
      end else if (enc_count != 4'sd0 && elapsed > {24'd0, cfg_tmo}) begin
         enc_count = 4'sd0;
      end
      if (cfg_invert) dir = -dir;

      if (s.button_raw != btn_seen) begin
         btn_seen     = s.button_raw;
         btn_since_ms = s.time_ms;
      end
      elapsed = s.time_ms - btn_since_ms;
      if (elapsed >= {24'd0, cfg_debounce} && btn_stable != btn_seen) begin
         btn_stable = btn_seen;
         r.press    = btn_stable;
      end
      r.step  = (dir > 0) ? STEP_POS : ((dir < 0) ? STEP_NEG : STEP_NONE);
      r.level = btn_stable;
   endtask

   // request driver: bursts of random length with random gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(negedge clock) begin
      sample_type s;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && req_seen != req_sent) begin
         // request still waiting for acceptance
      end else if (gap_left != 0) begin
         gap_left--;
         req_tvalid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
         s = sample_queue.pop_front();
         req_tdata  <= {5'd0, s.button_raw, s.phase_b, s.phase_a, s.time_ms};
         req_tvalid <= 1'b1;
         req_sent++;
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
         end else begin
            burst_left--;
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // receiver back-pressure, mode redrawn at random intervals
   rx_mode_type rx_mode = RX_OPEN;
   int       rx_left = 0;

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(8, 80);
      end else begin
         rx_left--;
      end
      case (rx_mode)
         RX_OPEN: rsp_tready <= 1'b1;
         RX_COIN: rsp_tready <= ($urandom_range(0, 1) == 1);
         RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= ($urandom_range(0, 9) != 0);
      endcase
   end

   // monitor, scoreboard and watchdog
   always @(posedge clock) begin
      sample_type s;
      report_type want;
      report_type got;
      logic    busy;
      if (!reset) begin
         busy = 1'b0;
         if (rsp_tvalid && rsp_tready) begin
            busy = 1'b1;
            got.step  = step_type'(rsp_tdata[1:0]);
            got.press = rsp_tdata[2];
            got.level = rsp_tdata[3];
            if (awaited_reports.size() == 0) begin
               $display("%0t unexpected response: expected none, got %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = awaited_reports.pop_front();
               if (got.step !== want.step) begin
                  $display("%0t step: expected %0d, got %0d", $time, want.step, rsp_tdata[1:0]);
                  mismatches++;
               end
               if (got.press !== want.press) begin
                  $display("%0t press_event: expected %0b, got %0b",
                           $time, want.press, got.press);
                  mismatches++;
               end
               if (got.level !== want.level) begin
                  $display("%0t button_level: expected %0b, got %0b",
                           $time, want.level, got.level);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            busy = 1'b1;
            s.time_ms    = req_tdata[31:0];
            s.phase_a    = req_tdata[32];
            s.phase_b    = req_tdata[33];
            s.button_raw = req_tdata[34];
            decode_sample(s, want);
            awaited_reports.push_back(want);
            req_seen++;
         end
         quiet_cycles = busy ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic queue_sample(input logic [31:0] t, input logic [1:0] pos,
                               input logic btn);
      sample_type s;
      logic [1:0] ph;
      stim_ms  = t;
      stim_pos = pos;
      stim_btn = btn;
      ph = gray_flip(pos);
      s.time_ms    = t;
      s.phase_a    = ph[1];
      s.phase_b    = ph[0];
      s.button_raw = btn;
      sample_queue.push_back(s);
      queued_total++;
   endtask

   // mostly clean rotation with holds, reversals, skipped states and
   // time steps clustered around the timeout and debounce windows
   task automatic queue_random(input int n);
      int          r;
      logic [31:0] t;
      logic [1:0]  pos;
      logic        btn;
      for (int i = 0; i < n; i++) begin
         t   = stim_ms;
         pos = stim_pos;
         btn = stim_btn;
         r = $urandom_range(0, 99);
         if (r < 40) t = t + $urandom_range(0, 2);
         else if (r < 65) t = t + $urandom_range(3, 12);
         else if (r < 78) t = t + {24'd0, cfg_tmo} + $urandom_range(0, 3) - 32'd1;
         else if (r < 90) t = t + {24'd0, cfg_debounce} + $urandom_range(0, 3) - 32'd2;
         else if (r < 96) t = t + $urandom_range(100, 5000);
         else t = $urandom();
         r = $urandom_range(0, 99);
         if (r < 50) begin
            if ($urandom_range(0, 11) == 0) stim_fwd = !stim_fwd;
            pos = stim_fwd ? pos + 2'd1 : pos - 2'd1;
         end else if (r >= 75 && r < 83) begin
            pos = pos + 2'd2;
         end else if (r >= 83) begin
            pos = 2'($urandom_range(0, 3));
         end
         if ($urandom_range(0, 9) == 0) btn = !btn;
         queue_sample(t, pos, btn);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (req_seen != queued_total || awaited_reports.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_SENSITIVITY: cfg_sens = val;
         CSR_INVERT_DIR: cfg_invert = val[0];
         CSR_QUAD_TMO: cfg_tmo = val;
         CSR_DEBOUNCE: cfg_debounce = val;
         default: ;
      endcase
   endtask

   task automatic run_phase(input logic [7:0] sens, input logic [7:0] inv,
                            input logic [7:0] tmo, input logic [7:0] db, input int n);
      wait_drained();
      repeat (2) @(negedge clock);
      write_reg(CSR_SENSITIVITY, sens);
      write_reg(CSR_INVERT_DIR, inv);
      write_reg(CSR_QUAD_TMO, tmo);
      write_reg(CSR_DEBOUNCE, db);
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      queue_random(n);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: threshold 4, timeout 80, debounce 20
      queue_sample(32'd0, 2'd0, 1'b0);
      queue_sample(32'd1, 2'd1, 1'b0);        // full forward turn
      queue_sample(32'd2, 2'd2, 1'b0);
      queue_sample(32'd3, 2'd3, 1'b0);
      queue_sample(32'd4, 2'd0, 1'b0);
      queue_sample(32'd5, 2'd3, 1'b0);        // full backward turn
      queue_sample(32'd6, 2'd2, 1'b0);
      queue_sample(32'd7, 2'd1, 1'b0);
      queue_sample(32'd8, 2'd0, 1'b0);
      queue_sample(32'd9, 2'd2, 1'b0);        // both phases flip: no count
      queue_sample(32'd10, 2'd3, 1'b0);
      queue_sample(32'd200, 2'd3, 1'b0);      // idle past timeout drops count
      queue_sample(32'd201, 2'd0, 1'b0);
      queue_sample(32'd202, 2'd0, 1'b1);      // press, accepted at 20 ms
      queue_sample(32'd221, 2'd0, 1'b1);
      queue_sample(32'd222, 2'd0, 1'b1);
      queue_sample(32'd223, 2'd0, 1'b0);      // bounce
      queue_sample(32'd224, 2'd0, 1'b1);
      queue_sample(32'd300, 2'd0, 1'b0);
      queue_sample(32'd320, 2'd0, 1'b0);
      queue_sample(32'hFFFF_FFF0, 2'd1, 1'b1);
      queue_sample(32'hFFFF_FFFF, 2'd2, 1'b1);
      queue_sample(32'h0000_0005, 2'd3, 1'b1); // wraps; leaves a partial count

      // first phase lowers the threshold onto the leftover count
      run_phase(8'd255, 8'hFF, 8'd255, 8'd0, 115);
      run_phase(8'd13, 8'hFE, 8'd0, 8'd255, 115);
      run_phase(8'd9, 8'd1, 8'd10, 8'd5, 115);
      run_phase(8'd5, 8'd0, 8'd80, 8'd20, 115);
      run_phase(8'd4, 8'd1, 8'd1, 8'd1, 115);
      run_phase(8'd12, 8'd0, 8'd30, 8'd3, 115);
      run_phase(8'd8, 8'd1, 8'd120, 8'd60, 115);
      run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 115);
      run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 115);

      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
